// ----- hdl/region_pc_stride_prefetcher_unit_macros.svh -----
// assertion helpers for the checker file
`ifndef REGION_PC_STRIDE_PREFETCHER_UNIT_MACROS_SVH
`define REGION_PC_STRIDE_PREFETCHER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RPSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpsp assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpsp assertion failed");

`endif

// ----- hdl/rpsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rpsp_pkg;

  localparam int PC_W   = 32;
  localparam int ADDR_W = 32;
  localparam int AGE_W  = 32;

  // result classification
  typedef enum logic [2:0] {
    OC_REGION_MISS   = 3'd0,
    OC_TRACKER_MISS  = 3'd1,
    OC_ZERO_STRIDE   = 3'd2,
    OC_STRIDE_CHANGE = 3'd3,
    OC_PREFETCH      = 3'd4
  } outcome_e;

  // control of the shared victim compare unit
  typedef struct packed {
    logic clr;
    logic en;
    logic elem_valid;
  } vic_ctl_t;

  // saturating age increment
  function automatic logic [AGE_W-1:0] sat_inc(input logic [AGE_W-1:0] a);
    return (a == {AGE_W{1'b1}}) ? a : a + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/region_pc_stride_prefetcher_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake               | payload
// ----------+-------------------------+------------------------------------------------
// access    | in_valid_i / in_ready_o | access_pc_i, access_addr_i
// result    | out_valid_o/out_ready_i | prefetch_valid_o, prefetch_addr_o, outcome_o
//
// one access at a time; each table has one read and one write port, walked one entry per cycle
// region hit: region search up to the hit, tracker search up to the hit, tracker age sweep;
// the sweep is skipped when the stride is zero; tracker miss: full tracker search, then the sweep
// region miss: full region search, region age sweep, tracker clear
// a result waits in the output register while the next access runs; a full register holds S_DONE
// rst_ni clears the sequencer, the region valid bits and the output valid flag

module region_pc_stride_prefetcher_unit #(
  parameter int REGION_ENTRIES     = 16,
  parameter int TRACKERS_PER_GROUP = 4,
  parameter int LINE_BITS          = 6,
  parameter int REGION_BITS        = 12
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire [rpsp_pkg::PC_W-1:0]    access_pc_i,
  input  wire [rpsp_pkg::ADDR_W-1:0]  access_addr_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic                        prefetch_valid_o,
  output logic [rpsp_pkg::ADDR_W-1:0] prefetch_addr_o,
  output logic [2:0]                  outcome_o
);
  import rpsp_pkg::*;

  localparam int RIDX_W    = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1;
  localparam int TIDX_W    = (TRACKERS_PER_GROUP > 1) ? $clog2(TRACKERS_PER_GROUP) : 1;
  localparam int TRK_TOTAL = REGION_ENTRIES * TRACKERS_PER_GROUP;
  localparam int TADDR_W   = (TRK_TOTAL > 1) ? $clog2(TRK_TOTAL) : 1;
  localparam int IDX_W     = (RIDX_W > TIDX_W) ? RIDX_W : TIDX_W;
  localparam bit OFF_NZ    = (REGION_BITS > LINE_BITS);
  localparam int OFF_W     = OFF_NZ ? (REGION_BITS - LINE_BITS) : 1;
  localparam int STR_W     = OFF_W + 1;
  localparam int TAG_W     = ADDR_W - REGION_BITS;
  localparam logic [RIDX_W-1:0] RIDX_LAST = RIDX_W'(REGION_ENTRIES - 1);
  localparam logic [TIDX_W-1:0] TIDX_LAST = TIDX_W'(TRACKERS_PER_GROUP - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RSCAN = 7'b0000010,  // region search
    S_RAGE  = 7'b0000100,  // region age sweep after a miss
    S_TCLR  = 7'b0001000,  // clear the new region's trackers
    S_TSCAN = 7'b0010000,  // tracker search inside the group
    S_TAGE  = 7'b0100000,  // tracker write-back and age sweep
    S_DONE  = 7'b1000000   // hand result to the output register
  } state_e;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } rgn_word_t;

  typedef struct packed {
    logic                    vld;
    logic [PC_W-1:0]         pc;
    logic [OFF_W-1:0]        off;
    logic signed [STR_W-1:0] stride;
    logic [AGE_W-1:0]        age;
  } trk_word_t;

  state_e state_q, state_d;

  // latched access
  logic [PC_W-1:0]   pc_q;
  logic [ADDR_W-1:0] addr_q;
  logic [TAG_W-1:0]  region;
  logic [OFF_W-1:0]  offset;

  // walk counters and selections
  logic [RIDX_W-1:0]       cidx_q, cidx_d;
  logic [RIDX_W-1:0]       grp_q, grp_d;
  logic [TIDX_W-1:0]       tidx_q, tidx_d;
  logic [TADDR_W-1:0]      tbase_q, tbase_d;
  logic [TIDX_W-1:0]       keep_q, keep_d;
  logic signed [STR_W-1:0] kstride_q, kstride_d;

  // region valid bits, cleared by reset
  logic [REGION_ENTRIES-1:0] rvld_q, rvld_d;

  // pending result
  logic              res_pv_q, res_pv_d;
  logic [ADDR_W-1:0] res_pa_q, res_pa_d;
  outcome_e          res_oc_q, res_oc_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              pv_q;
  logic [ADDR_W-1:0] pa_q;
  outcome_e          oc_q;
  logic              load_out;

  // region table
  rgn_word_t         rgn_mem [REGION_ENTRIES];
  rgn_word_t         rgn_rd_q, rgn_wdata;
  logic [RIDX_W-1:0] rgn_raddr;
  logic              rgn_we;

  // tracker table
  trk_word_t          trk_mem [TRK_TOTAL];
  trk_word_t          trk_rd_q, trk_wdata, trk_keep;
  logic [TADDR_W-1:0] trk_raddr, trk_addr, trk_addr_nxt;
  logic               trk_we;

  // shared victim compare unit
  vic_ctl_t         vic_ctl;
  logic [AGE_W-1:0] vic_age;
  logic [IDX_W-1:0] vic_idx, vic_out;

  // datapath helpers
  logic                    rgn_hit, trk_hit, r_last, t_last;
  logic signed [STR_W-1:0] cur_stride;
  logic signed [STR_W:0]   line_s;
  logic [ADDR_W-1:0]       line_ext, pf_addr;

  assign region = TAG_W'(addr_q >> REGION_BITS);
  assign offset = OFF_NZ ? OFF_W'(addr_q >> LINE_BITS) : '0;

  assign trk_addr     = tbase_q + TADDR_W'(tidx_q);
  assign trk_addr_nxt = trk_addr + 1'b1;
  assign r_last       = (cidx_q == RIDX_LAST);
  assign t_last       = (tidx_q == TIDX_LAST);

  assign rgn_hit = rvld_q[cidx_q] && (rgn_rd_q.tag == region);
  assign trk_hit = trk_rd_q.vld && (trk_rd_q.pc == pc_q);

  // stride against the tracker under inspection, and the line it points at
  assign cur_stride = $signed({1'b0, offset}) - $signed({1'b0, trk_rd_q.off});
  assign line_s     = $signed({2'b00, offset}) + (STR_W + 1)'(cur_stride);
  assign line_ext   = ADDR_W'(line_s);
  assign pf_addr    = ((addr_q >> REGION_BITS) << REGION_BITS) + (line_ext << LINE_BITS);

  // word written back for the tracker that is kept young
  assign trk_keep = '{vld: 1'b1, pc: pc_q, off: offset, stride: kstride_q, age: '0};

  rpsp_victim #(
    .IDX_W (IDX_W)
  ) u_victim (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (vic_ctl),
    .age_i    (vic_age),
    .idx_i    (vic_idx),
    .victim_o (vic_out)
  );

  always_comb begin
    state_d     = state_q;
    cidx_d      = cidx_q;
    grp_d       = grp_q;
    tidx_d      = tidx_q;
    tbase_d     = tbase_q;
    keep_d      = keep_q;
    kstride_d   = kstride_q;
    rvld_d      = rvld_q;
    res_pv_d    = res_pv_q;
    res_pa_d    = res_pa_q;
    res_oc_d    = res_oc_q;
    load_out    = 1'b0;
    rgn_raddr   = '0;
    rgn_we      = 1'b0;
    rgn_wdata   = rgn_rd_q;
    trk_raddr   = trk_addr;
    trk_we      = 1'b0;
    trk_wdata   = trk_rd_q;
    vic_ctl     = '0;
    vic_age     = '0;
    vic_idx     = '0;

    unique case (state_q)
      S_IDLE: begin
        // entry 0 is read on the accepting edge
        if (in_valid_i) begin
          cidx_d      = '0;
          vic_ctl.clr = 1'b1;
          state_d     = S_RSCAN;
        end
      end

      S_RSCAN: begin
        vic_ctl.en         = 1'b1;
        vic_ctl.elem_valid = rvld_q[cidx_q];
        vic_age            = rgn_rd_q.age;
        vic_idx            = IDX_W'(cidx_q);
        rgn_raddr          = cidx_q + 1'b1;
        if (rgn_hit) begin
          grp_d       = cidx_q;
          tbase_d     = TADDR_W'(cidx_q * TRACKERS_PER_GROUP);
          trk_raddr   = TADDR_W'(cidx_q * TRACKERS_PER_GROUP);
          tidx_d      = '0;
          vic_ctl.clr = 1'b1;
          state_d     = S_TSCAN;
        end else if (r_last) begin
          grp_d     = RIDX_W'(vic_out);
          rgn_raddr = '0;
          cidx_d    = '0;
          state_d   = S_RAGE;
        end else begin
          cidx_d = cidx_q + 1'b1;
        end
      end

      S_RAGE: begin
        // read-modify-write sweep: every other age steps up, the victim takes the new region
        rgn_we = 1'b1;
        if (cidx_q == grp_q) begin
          rgn_wdata = '{tag: region, age: '0};
        end else begin
          rgn_wdata = '{tag: rgn_rd_q.tag, age: sat_inc(rgn_rd_q.age)};
        end
        if (r_last) begin
          rvld_d[grp_q] = 1'b1;
          tbase_d       = TADDR_W'(grp_q * TRACKERS_PER_GROUP);
          tidx_d        = '0;
          state_d       = S_TCLR;
        end else begin
          rgn_raddr = cidx_q + 1'b1;
          cidx_d    = cidx_q + 1'b1;
        end
      end

      S_TCLR: begin
        trk_we    = 1'b1;
        trk_wdata = '0;
        if (t_last) begin
          res_pv_d = 1'b0;
          res_pa_d = '0;
          res_oc_d = OC_REGION_MISS;
          state_d  = S_DONE;
        end else begin
          tidx_d = tidx_q + 1'b1;
        end
      end

      S_TSCAN: begin
        vic_ctl.en         = 1'b1;
        vic_ctl.elem_valid = trk_rd_q.vld;
        vic_age            = trk_rd_q.age;
        vic_idx            = IDX_W'(tidx_q);
        trk_raddr          = trk_addr_nxt;
        if (trk_hit) begin
          if (cur_stride == '0) begin
            // same line again: nothing changes
            res_pv_d = 1'b0;
            res_pa_d = '0;
            res_oc_d = OC_ZERO_STRIDE;
            state_d  = S_DONE;
          end else begin
            keep_d    = tidx_q;
            kstride_d = cur_stride;
            if (cur_stride == trk_rd_q.stride) begin
              res_pv_d = 1'b1;
              res_pa_d = pf_addr;
              res_oc_d = OC_PREFETCH;
            end else begin
              res_pv_d = 1'b0;
              res_pa_d = '0;
              res_oc_d = OC_STRIDE_CHANGE;
            end
            tidx_d    = '0;
            trk_raddr = tbase_q;
            state_d   = S_TAGE;
          end
        end else if (t_last) begin
          // allocate: first free slot, else the oldest
          keep_d    = TIDX_W'(vic_out);
          kstride_d = '0;
          res_pv_d  = 1'b0;
          res_pa_d  = '0;
          res_oc_d  = OC_TRACKER_MISS;
          tidx_d    = '0;
          trk_raddr = tbase_q;
          state_d   = S_TAGE;
        end else begin
          tidx_d = tidx_q + 1'b1;
        end
      end

      S_TAGE: begin
        trk_we = 1'b1;
        if (tidx_q == keep_q) begin
          trk_wdata = trk_keep;
        end else begin
          trk_wdata     = trk_rd_q;
          trk_wdata.age = sat_inc(trk_rd_q.age);
        end
        if (t_last) begin
          state_d = S_DONE;
        end else begin
          trk_raddr = trk_addr_nxt;
          tidx_d    = tidx_q + 1'b1;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cidx_q      <= '0;
      grp_q       <= '0;
      tidx_q      <= '0;
      tbase_q     <= '0;
      keep_q      <= '0;
      rvld_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cidx_q      <= cidx_d;
      grp_q       <= grp_d;
      tidx_q      <= tidx_d;
      tbase_q     <= tbase_d;
      keep_q      <= keep_d;
      rvld_q      <= rvld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pc_q   <= access_pc_i;
      addr_q <= access_addr_i;
    end
    kstride_q <= kstride_d;
    res_pv_q  <= res_pv_d;
    res_pa_q  <= res_pa_d;
    res_oc_q  <= res_oc_d;
    if (load_out) begin
      pv_q <= res_pv_q;
      pa_q <= res_pa_q;
      oc_q <= res_oc_q;
    end
  end

  // region table, registered read
  always_ff @(posedge clk_i) begin
    if (rgn_we) begin
      rgn_mem[cidx_q] <= rgn_wdata;
    end
    rgn_rd_q <= rgn_mem[rgn_raddr];
  end

  // tracker table, registered read
  always_ff @(posedge clk_i) begin
    if (trk_we) begin
      trk_mem[trk_addr] <= trk_wdata;
    end
    trk_rd_q <= trk_mem[trk_raddr];
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign prefetch_valid_o = pv_q;
  assign prefetch_addr_o  = pa_q;
  assign outcome_o        = oc_q;

endmodule

`default_nettype wire

// ----- hdl/rpsp_victim.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rpsp_victim #(
  parameter int IDX_W = 4
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  rpsp_pkg::vic_ctl_t       ctl_i,
  input  wire [rpsp_pkg::AGE_W-1:0] age_i,
  input  wire [IDX_W-1:0]          idx_i,
  output logic [IDX_W-1:0]         victim_o
);
  import rpsp_pkg::*;

  logic             have_inv_q, have_inv_d;
  logic             have_best_q, have_best_d;
  logic [AGE_W-1:0] best_age_q, best_age_d;
  logic [IDX_W-1:0] vic_q, vic_d;

  // first invalid element wins, else the oldest, lowest index on ties
  always_comb begin
    have_inv_d  = have_inv_q;
    have_best_d = have_best_q;
    best_age_d  = best_age_q;
    vic_d       = vic_q;
    if (ctl_i.en && !have_inv_q) begin
      if (!ctl_i.elem_valid) begin
        vic_d      = idx_i;
        have_inv_d = 1'b1;
      end else if (!have_best_q || (age_i > best_age_q)) begin
        vic_d       = idx_i;
        best_age_d  = age_i;
        have_best_d = 1'b1;
      end
    end
  end

  assign victim_o = vic_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_inv_q  <= 1'b0;
      have_best_q <= 1'b0;
      best_age_q  <= '0;
      vic_q       <= '0;
    end else if (ctl_i.clr) begin
      have_inv_q  <= 1'b0;
      have_best_q <= 1'b0;
      best_age_q  <= '0;
      vic_q       <= '0;
    end else begin
      have_inv_q  <= have_inv_d;
      have_best_q <= have_best_d;
      best_age_q  <= best_age_d;
      vic_q       <= vic_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rpsp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "region_pc_stride_prefetcher_unit_macros.svh"

module rpsp_checker (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         in_valid_i,
  input wire                         in_ready_o,
  input wire                         out_valid_o,
  input wire                         out_ready_i,
  input wire                         prefetch_valid_o,
  input wire [rpsp_pkg::ADDR_W-1:0]  prefetch_addr_o,
  input wire [2:0]                   outcome_o
);
  import rpsp_pkg::*;

  // a stalled result holds
  `RPSP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(prefetch_addr_o) && $stable(outcome_o) && $stable(prefetch_valid_o))

  // the prefetch flag goes with the prefetch outcome only
  `RPSP_ASSERT_IMPL(a_pf_flag, clk_i, rst_ni, out_valid_o, prefetch_valid_o == (outcome_o == OC_PREFETCH))

  // no address without a prefetch
  `RPSP_ASSERT_IMPL(a_pf_zero, clk_i, rst_ni, out_valid_o && !prefetch_valid_o, prefetch_addr_o == '0)

  // an accepted transaction keeps the block busy for at least the next cycle
  `RPSP_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind region_pc_stride_prefetcher_unit rpsp_checker u_rpsp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .prefetch_valid_o (prefetch_valid_o),
  .prefetch_addr_o  (prefetch_addr_o),
  .outcome_o        (outcome_o)
);

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rpsp_pkg::*;

  localparam int REGION_ENTRIES     = 16;
  localparam int TRACKERS_PER_GROUP = 4;
  localparam int LINE_BITS          = 6;
  localparam int REGION_BITS        = 12;
  localparam int TAG_W              = ADDR_W - REGION_BITS;
  localparam int OFF_W              = REGION_BITS - LINE_BITS;
  localparam int TRACKER_TOTAL      = REGION_ENTRIES * TRACKERS_PER_GROUP;
  // slowest transaction is a region miss
  localparam int DRAIN_CYCLES       = 64;
  localparam int WATCHDOG_LIMIT     = 2000;
  localparam int RANDOM_ITEMS       = 880;

  typedef struct packed {
    logic              pf_valid;
    logic [ADDR_W-1:0] pf_addr;
    outcome_e          oc;
  } prefetch_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic [PC_W-1:0]   access_pc = '0;
  logic [ADDR_W-1:0] access_addr = '0;
  logic              out_ready = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic              prefetch_valid_o;
  logic [ADDR_W-1:0] prefetch_addr_o;
  logic [2:0]        outcome_o;

  bit idle_en = 1'b0;
  int error_count = 0;
  int items_sent = 0;

  prefetch_result_t pending_outcomes[$];

  // predictor state
  logic [TAG_W-1:0]        region_tag_m   [REGION_ENTRIES];
  bit                      region_valid_m [REGION_ENTRIES];
  logic [AGE_W-1:0]        region_age_m   [REGION_ENTRIES];
  logic [PC_W-1:0]         tracker_pc_m   [TRACKER_TOTAL];
  logic [OFF_W-1:0]        tracker_last_m [TRACKER_TOTAL];
  logic signed [OFF_W:0]   tracker_stride_m [TRACKER_TOTAL];
  bit                      tracker_valid_m [TRACKER_TOTAL];
  logic [AGE_W-1:0]        tracker_age_m  [TRACKER_TOTAL];

  region_pc_stride_prefetcher_unit #(
    .REGION_ENTRIES    (REGION_ENTRIES),
    .TRACKERS_PER_GROUP(TRACKERS_PER_GROUP),
    .LINE_BITS         (LINE_BITS),
    .REGION_BITS       (REGION_BITS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .access_pc_i     (access_pc),
    .access_addr_i   (access_addr),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .prefetch_valid_o(prefetch_valid_o),
    .prefetch_addr_o (prefetch_addr_o),
    .outcome_o       (outcome_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready <= idle_en ? ($urandom_range(99) >= 30) : 1'b1;
  end

  function automatic void clear_prefetch_state();
    int i;
    for (i = 0; i < REGION_ENTRIES; i++) begin
      region_tag_m[i]   = '0;
      region_valid_m[i] = 1'b0;
      region_age_m[i]   = '0;
    end
    for (i = 0; i < TRACKER_TOTAL; i++) begin
      tracker_pc_m[i]     = '0;
      tracker_last_m[i]   = '0;
      tracker_stride_m[i] = '0;
      tracker_valid_m[i]  = 1'b0;
      tracker_age_m[i]    = '0;
    end
  endfunction

  // classify one access, update the region and tracker tables
  function automatic prefetch_result_t compute_prefetch(input logic [PC_W-1:0] pc,
                                                       input logic [ADDR_W-1:0] addr);
    prefetch_result_t res;
    logic [TAG_W-1:0] region;
    logic [OFF_W-1:0] offset;
    logic [ADDR_W-1:0] line;
    int i, hit, th, victim, base, cur, prev;
    res.pf_valid = 1'b0;
    res.pf_addr  = '0;
    res.oc       = OC_REGION_MISS;
    region = addr[ADDR_W-1:REGION_BITS];
    offset = addr[REGION_BITS-1:LINE_BITS];
    hit = -1;
    for (i = 0; i < REGION_ENTRIES; i++) begin
      if (hit < 0 && region_valid_m[i] && region_tag_m[i] == region) hit = i;
    end
    if (hit >= 0) begin
      base = hit * TRACKERS_PER_GROUP;
      th = -1;
      for (i = base; i < base + TRACKERS_PER_GROUP; i++) begin
        if (th < 0 && tracker_valid_m[i] && tracker_pc_m[i] == pc) th = i;
      end
      if (th >= 0) begin
        prev = tracker_stride_m[th];
        cur  = int'(offset) - int'(tracker_last_m[th]);
        if (cur == 0) begin
          res.oc = OC_ZERO_STRIDE;
        end else begin
          tracker_last_m[th]   = offset;
          tracker_stride_m[th] = cur[OFF_W:0];
          for (i = base; i < base + TRACKERS_PER_GROUP; i++) begin
            if (tracker_age_m[i] != '1) tracker_age_m[i] = tracker_age_m[i] + 1'b1;
          end
          tracker_age_m[th] = '0;
          if (cur != prev) begin
            res.oc = OC_STRIDE_CHANGE;
          end else begin
            // target line may fall outside the region, wraps modulo 2^32
            line = ADDR_W'(int'(offset) + cur);
            res.pf_valid = 1'b1;
            res.pf_addr  = {region, {REGION_BITS{1'b0}}} + (line << LINE_BITS);
            res.oc       = OC_PREFETCH;
          end
        end
      end else begin
        victim = -1;
        for (i = base; i < base + TRACKERS_PER_GROUP; i++) begin
          if (victim < 0 && !tracker_valid_m[i]) victim = i;
        end
        if (victim < 0) begin
          victim = base;
          for (i = base + 1; i < base + TRACKERS_PER_GROUP; i++) begin
            if (tracker_age_m[i] > tracker_age_m[victim]) victim = i;
          end
        end
        tracker_pc_m[victim]     = pc;
        tracker_last_m[victim]   = offset;
        tracker_stride_m[victim] = '0;
        tracker_valid_m[victim]  = 1'b1;
        for (i = base; i < base + TRACKERS_PER_GROUP; i++) begin
          if (tracker_age_m[i] != '1) tracker_age_m[i] = tracker_age_m[i] + 1'b1;
        end
        tracker_age_m[victim] = '0;
        res.oc = OC_TRACKER_MISS;
      end
    end else begin
      victim = -1;
      for (i = 0; i < REGION_ENTRIES; i++) begin
        if (victim < 0 && !region_valid_m[i]) victim = i;
      end
      if (victim < 0) begin
        victim = 0;
        for (i = 1; i < REGION_ENTRIES; i++) begin
          if (region_age_m[i] > region_age_m[victim]) victim = i;
        end
      end
      base = victim * TRACKERS_PER_GROUP;
      for (i = base; i < base + TRACKERS_PER_GROUP; i++) begin
        tracker_valid_m[i] = 1'b0;
        tracker_age_m[i]   = '0;
      end
      region_tag_m[victim]   = region;
      region_valid_m[victim] = 1'b1;
      for (i = 0; i < REGION_ENTRIES; i++) begin
        if (region_age_m[i] != '1) region_age_m[i] = region_age_m[i] + 1'b1;
      end
      region_age_m[victim] = '0;
    end
    return res;
  endfunction

  // address of a line in a region, random byte within the line
  function automatic logic [ADDR_W-1:0] line_addr(input logic [TAG_W-1:0] tag,
                                                  input int offset);
    return {tag, OFF_W'(offset), LINE_BITS'($urandom)};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // called at a rising edge; returns at the edge that accepts the transaction
  task automatic send_access(input logic [PC_W-1:0] pc, input logic [ADDR_W-1:0] addr);
    if (idle_en && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 30);
    end
    in_valid    <= 1'b1;
    access_pc   <= pc;
    access_addr <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    pending_outcomes.push_back(compute_prefetch(pc, addr));
    items_sent++;
  endtask

  // hold the sender off until every pending result is back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_outcomes.size() != 0);
  endtask

  always @(posedge clk_i) begin : result_check
    prefetch_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(outcome_o), '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (prefetch_valid_o !== want.pf_valid)
          report_mismatch("prefetch_valid", 32'(prefetch_valid_o), 32'(want.pf_valid));
        if (prefetch_addr_o !== want.pf_addr)
          report_mismatch("prefetch_addr", prefetch_addr_o, want.pf_addr);
        if (outcome_o !== want.oc)
          report_mismatch("outcome", 32'(outcome_o), 32'(want.oc));
      end
    end
  end

  // runs until too many cycles pass without any transaction
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // miss, tracker allocate, repeat, stride change, then prefetch
  task automatic test_basic_sequence();
    logic [TAG_W-1:0] tag;
    tag = 20'h12345;
    send_access(32'h0000_1000, line_addr(tag, 0));
    send_access(32'h0000_1000, line_addr(tag, 0));
    send_access(32'h0000_1000, line_addr(tag, 0));
    send_access(32'h0000_1000, line_addr(tag, 1));
    send_access(32'h0000_1000, line_addr(tag, 2));
  endtask

  // prefetch target past the top of memory and below address zero
  task automatic test_address_wrap();
    send_access(32'hFFFF_FFFF, line_addr('1, 61));
    send_access(32'hFFFF_FFFF, line_addr('1, 61));
    send_access(32'hFFFF_FFFF, line_addr('1, 62));
    send_access(32'hFFFF_FFFF, {{TAG_W{1'b1}}, {OFF_W{1'b1}}, {LINE_BITS{1'b1}}});
    send_access(32'h0000_0000, line_addr('0, 2));
    send_access(32'h0000_0000, line_addr('0, 2));
    send_access(32'h0000_0000, line_addr('0, 1));
    send_access(32'h0000_0000, {ADDR_W{1'b0}});
  endtask

  // largest positive and negative strides, prefetch beyond the region end
  task automatic test_stride_extremes();
    logic [TAG_W-1:0] tag;
    tag = 20'h5A5A5;
    send_access(32'hA5A5_A5A5, line_addr(tag, 0));
    send_access(32'hA5A5_A5A5, line_addr(tag, 0));
    send_access(32'hA5A5_A5A5, line_addr(tag, 63));
    send_access(32'hA5A5_A5A5, line_addr(tag, 0));
    send_access(32'hA5A5_A5A5, line_addr(tag, 31));
    send_access(32'hA5A5_A5A5, line_addr(tag, 62));
  endtask

  // five pcs in one region, the first is evicted as oldest
  task automatic test_tracker_eviction();
    logic [TAG_W-1:0] tag;
    int k;
    tag = 20'h3C3C3;
    send_access(32'h0000_0040, line_addr(tag, 7));
    for (k = 0; k < 5; k++) send_access(32'h0000_0040 + 32'(k * 4), line_addr(tag, 7));
    send_access(32'h0000_0040, line_addr(tag, 9));
  endtask

  // constant-stride streams over a region pool larger than the table, plus noise
  task automatic test_random_streams(input int n_items);
    logic [TAG_W-1:0] region_pool [24];
    logic [PC_W-1:0]  pc_pool [6];
    int first, kind, r, p, off, stride, len, k;
    bit paused;
    first  = items_sent;
    paused = 1'b0;
    for (k = 0; k < 24; k++) region_pool[k] = TAG_W'($urandom);
    for (k = 0; k < 6; k++) pc_pool[k] = $urandom;
    idle_en = 1'b0;
    while (items_sent - first < n_items) begin
      if (items_sent - first >= n_items / 3) idle_en = 1'b1;
      if (!paused && items_sent - first >= n_items / 2) begin
        wait_all_results();
        paused = 1'b1;
      end
      kind = $urandom_range(99);
      r = ($urandom_range(99) < 80) ? $urandom_range(13) : $urandom_range(23);
      p = $urandom_range(5);
      if (kind < 10) begin
        send_access($urandom, $urandom);
      end else if (kind < 18) begin
        send_access(pc_pool[p], line_addr(region_pool[r], $urandom_range(63)));
      end else begin
        if ($urandom_range(99) < 75) stride = int'($urandom_range(16)) - 8;
        else stride = int'($urandom_range(126)) - 63;
        off = $urandom_range(63);
        len = $urandom_range(3, 8);
        for (k = 0; k < len && off >= 0 && off <= 63; k++) begin
          send_access(pc_pool[p], line_addr(region_pool[r], off));
          off += stride;
        end
      end
    end
  endtask

  initial begin
    clear_prefetch_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_en = 1'b1;
    test_basic_sequence();
    test_address_wrap();
    test_stride_extremes();
    test_tracker_eviction();
    test_random_streams(RANDOM_ITEMS);
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/rpsp_pkg.sv
hdl/rpsp_victim.sv
hdl/region_pc_stride_prefetcher_unit.sv
hdl/rpsp_checker.sv
bench/tb.sv
